/* hw/rtl/mushy_zone_phase_fractions_macros.svh */
// Assertion macros for the mushy zone phase fraction block
`ifndef MUSHY_ZONE_PHASE_FRACTIONS_MACROS_SVH
`define MUSHY_ZONE_PHASE_FRACTIONS_MACROS_SVH
// assert that a implies b on the next edge, outside reset
`define MZ_ASSERT_NEXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("lbl failed");
// assert that a implies b on the same edge, outside reset
`define MZ_ASSERT_NOW(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("lbl failed");
`endif

/* hw/rtl/mzpf_pkg.sv */
// Shared constants and helper types for the mushy zone phase fraction block
`default_nettype none
package mzpf_pkg;
   localparam int FRAC_W    = 17;
   localparam int MSLOPE_W  = 33;
   localparam int VSLOPE_W  = 47;
   localparam int SVSLOPE_W = 48;
   localparam logic [1:0] REG_SOLIDUS  = 2'd0;
   localparam logic [1:0] REG_LIQUIDUS = 2'd1;
   localparam logic [1:0] REG_RHO_S    = 2'd2;
   localparam logic [1:0] REG_RHO_L    = 2'd3;
   typedef struct packed {
      logic       valid;
      logic       mushy;
   } mzpf_ctl_type;
endpackage
`default_nettype wire

/* hw/rtl/mushy_zone_phase_fractions.sv */
// Top level: lever rule phase fractions with temperature derivatives
// Pipeline: rsp_valid rises after two 33-stage mass dividers, four product stages,
// two 48-stage volume dividers and the output register, in that order.
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// Reset: synchronous, clears all valid bits and sets registers to defaults.
`default_nettype none
module mushy_zone_phase_fractions
   import mzpf_pkg::*;
#(
   parameter int TEMP_BITS    = 20,
   parameter int FRAC_BITS    = 16,
   parameter int DENSITY_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [TEMP_BITS-1:0]      req_temperature,
   output logic                           rsp_valid,
   output logic [FRAC_BITS:0]             rsp_liquid_mass_frac,
   output logic [2*FRAC_BITS:0]           rsp_liquid_mass_slope,
   output logic [FRAC_BITS:0]             rsp_solid_mass_frac,
   output logic signed [2*FRAC_BITS:0]    rsp_solid_mass_slope,
   output logic [FRAC_BITS:0]             rsp_liquid_volume_frac,
   output logic [VSLOPE_W-1:0]            rsp_liquid_volume_slope,
   output logic [FRAC_BITS:0]             rsp_solid_volume_frac,
   output logic signed [SVSLOPE_W-1:0]    rsp_solid_volume_slope,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [3:0]                paddr,
   input  wire logic [31:0]               pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   `include "mushy_zone_phase_fractions_macros.svh"

   localparam int F1_W  = FRAC_BITS + 1;             // fraction incl. one
   localparam int P_W   = 2*FRAC_BITS + 1;           // mass slope
   localparam int X_W   = F1_W + DENSITY_BITS;       // weighted sum
   localparam int GN_W  = F1_W + DENSITY_BITS + FRAC_BITS;
   localparam int RR_W  = 2*DENSITY_BITS;
   localparam int QN_W  = P_W + RR_W + 2*FRAC_BITS;
   localparam int XX_W  = 2*X_W;
   localparam logic [P_W-1:0] SLOPE_ONE = P_W'(1) << (2*FRAC_BITS);
   localparam logic [F1_W-1:0] ONE = F1_W'(1) << FRAC_BITS;

   // configuration registers
   logic [TEMP_BITS-1:0]    sol_ff, liq_ff;
   logic [DENSITY_BITS-1:0] rs_ff, rl_ff;
   logic                    wr;
   logic [1:0]              ridx;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign wr     = psel && penable && pwrite;
   assign ridx   = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         sol_ff <= '0;
         liq_ff <= '1;
         rs_ff  <= DENSITY_BITS'(1);
         rl_ff  <= DENSITY_BITS'(1);
      end else if (wr) begin
         unique case (ridx)
            REG_SOLIDUS:  sol_ff <= pwdata[TEMP_BITS-1:0];
            REG_LIQUIDUS: liq_ff <= pwdata[TEMP_BITS-1:0];
            REG_RHO_S:    rs_ff  <= pwdata[DENSITY_BITS-1:0];
            REG_RHO_L:    rl_ff  <= pwdata[DENSITY_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         REG_SOLIDUS:  prdata = 32'(sol_ff);
         REG_LIQUIDUS: prdata = 32'(liq_ff);
         REG_RHO_S:    prdata = 32'(rs_ff);
         REG_RHO_L:    prdata = 32'(rl_ff);
         default:      prdata = '0;
      endcase
   end

   // stage A: classify the sample against the zone
   logic [TEMP_BITS-1:0] span_a;
   logic [TEMP_BITS-1:0] off_a;
   logic                 mushy_a, below_a;
   assign below_a = req_temperature < sol_ff;
   assign mushy_a = !below_a && (liq_ff > sol_ff) && (req_temperature <= liq_ff);
   assign span_a  = liq_ff - sol_ff;
   assign off_a   = req_temperature - sol_ff;

   // mass fraction and slope dividers run side by side at equal depth
   logic [1:0]                zone_a, tag_f;
   logic [2*DENSITY_BITS-1:0] dens_a, tag_p;
   logic [DENSITY_BITS-1:0]   rs_a, rl_a;
   assign rs_a   = (rs_ff == '0) ? DENSITY_BITS'(1) : rs_ff;
   assign rl_a   = (rl_ff == '0) ? DENSITY_BITS'(1) : rl_ff;
   assign zone_a = {mushy_a, below_a};
   assign dens_a = {rs_a, rl_a};

   logic vf, vp;
   logic [P_W-1:0]  fq_w;
   logic [F1_W-1:0] fq;
   logic [P_W-1:0]  pq;
   assign fq = fq_w[F1_W-1:0];

   mzpf_divider #(.NUM_W(TEMP_BITS+FRAC_BITS), .DEN_W(TEMP_BITS), .Q_W(P_W),
                  .TAG_W(2)) u_fdiv (
      .clock, .reset, .in_valid(start),
      .num({off_a, FRAC_BITS'(0)}), .den(mushy_a ? span_a : TEMP_BITS'(1)),
      .tag_in(zone_a), .out_valid(vf), .quot(fq_w), .tag_out(tag_f));

   mzpf_divider #(.NUM_W(P_W), .DEN_W(TEMP_BITS), .Q_W(P_W),
                  .TAG_W(2*DENSITY_BITS)) u_pdiv (
      .clock, .reset, .in_valid(start),
      .num(SLOPE_ONE), .den(mushy_a ? span_a : TEMP_BITS'(1)),
      .tag_in(dens_a), .out_valid(vp), .quot(pq), .tag_out(tag_p));

   // stage B: select fraction and slope
   logic [F1_W-1:0] f_b_in;
   logic [P_W-1:0]  p_b_in;
   always_comb begin
      priority if (tag_f[0]) begin
         f_b_in = '0;
         p_b_in = '0;
      end else if (tag_f[1]) begin
         f_b_in = fq;
         p_b_in = pq;
      end else begin
         f_b_in = ONE;
         p_b_in = '0;
      end
   end

   logic                    vb_ff;
   logic [F1_W-1:0]         fb_ff;
   logic [P_W-1:0]          pb_ff;
   logic [DENSITY_BITS-1:0] rsb_ff, rlb_ff;
   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else       vb_ff <= vf;
      fb_ff  <= f_b_in;
      pb_ff  <= p_b_in;
      rsb_ff <= tag_p[2*DENSITY_BITS-1:DENSITY_BITS];
      rlb_ff <= tag_p[DENSITY_BITS-1:0];
   end

   // stage C: density products
   logic              vc_ff;
   logic [X_W-1:0]    xa_ff, xb_ff;
   logic [GN_W-1:0]   gn_ff;
   logic [RR_W-1:0]   rr_ff;
   logic [P_W-1:0]    pc_ff;
   logic [F1_W-1:0]   fc_ff;
   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else       vc_ff <= vb_ff;
      xa_ff <= X_W'((ONE - fb_ff) * rlb_ff);
      xb_ff <= X_W'(fb_ff * rsb_ff);
      gn_ff <= GN_W'(fb_ff * rsb_ff) << FRAC_BITS;
      rr_ff <= RR_W'(rsb_ff * rlb_ff);
      pc_ff <= pb_ff;
      fc_ff <= fb_ff;
   end

   // stage D: sum and slope numerator product
   logic              vd_ff;
   logic [X_W-1:0]    xd_ff;
   logic [GN_W-1:0]   gnd_ff;
   logic [P_W+RR_W-1:0] prr_ff;
   logic [P_W-1:0]    pd_ff;
   logic [F1_W-1:0]   fd_ff;
   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else       vd_ff <= vc_ff;
      xd_ff  <= xa_ff + xb_ff;
      gnd_ff <= gn_ff;
      prr_ff <= (P_W+RR_W)'(pc_ff * rr_ff);
      pd_ff  <= pc_ff;
      fd_ff  <= fc_ff;
   end

   // stage E: square of the weighted sum
   logic              ve_ff;
   logic [XX_W-1:0]   xxe_ff;
   logic [X_W-1:0]    xe_ff;
   logic [GN_W-1:0]   gne_ff;
   logic [P_W+RR_W-1:0] prre_ff;
   logic [P_W-1:0]    pe_ff;
   logic [F1_W-1:0]   fe_ff;
   always_ff @(posedge clock) begin
      if (reset) ve_ff <= 1'b0;
      else       ve_ff <= vd_ff;
      xxe_ff  <= XX_W'(xd_ff * xd_ff);
      xe_ff   <= xd_ff;
      gne_ff  <= gnd_ff;
      prre_ff <= prr_ff;
      pe_ff   <= pd_ff;
      fe_ff   <= fd_ff;
   end

   // volume fraction divider, as deep as the slope divider; fraction never exceeds one
   localparam int T2_W = F1_W + P_W;
   localparam int QQ_W = VSLOPE_W + 1;
   logic             vg, vq;
   logic [QQ_W-1:0]  gq_w;
   logic [F1_W-1:0]  gq;
   logic [T2_W-1:0]  tag_g;
   assign gq = gq_w[F1_W-1:0];
   mzpf_divider #(.NUM_W(GN_W), .DEN_W(X_W), .Q_W(QQ_W), .TAG_W(T2_W)) u_gdiv (
      .clock, .reset, .in_valid(ve_ff), .num(gne_ff), .den(xe_ff),
      .tag_in({fe_ff, pe_ff}), .out_valid(vg), .quot(gq_w), .tag_out(tag_g));

   // the slope numerator may exceed den*2^QQ_W: flag it and carry the flag along
   logic [QN_W-1:0] hi_chk;
   logic            ovf_e, ovf_q;
   logic [QQ_W-1:0] qq;
   assign hi_chk = {prre_ff, (2*FRAC_BITS)'(0)} >> QQ_W;
   assign ovf_e  = QN_W'(hi_chk) >= QN_W'(xxe_ff);

   // volume slope divider: one guard bit above the saturation limit
   mzpf_divider #(.NUM_W(QN_W), .DEN_W(XX_W), .Q_W(QQ_W), .TAG_W(1)) u_qdiv (
      .clock, .reset, .in_valid(ve_ff),
      .num({prre_ff, (2*FRAC_BITS)'(0)}), .den(xxe_ff),
      .tag_in(ovf_e), .out_valid(vq), .quot(qq), .tag_out(ovf_q));

   // output register
   logic [VSLOPE_W-1:0] qsat;
   logic [F1_W-1:0]     fo;
   logic [P_W-1:0]      po;
   assign fo   = tag_g[T2_W-1:P_W];
   assign po   = tag_g[P_W-1:0];
   assign qsat = (po == '0) ? '0 :
                 (ovf_q || qq[QQ_W-1]) ? '1 : qq[VSLOPE_W-1:0];

   logic vo_ff;
   logic [F1_W-1:0] lmf_ff, smf_ff, lvf_ff, svf_ff;
   logic [P_W-1:0] lms_ff, sms_ff;
   logic [VSLOPE_W-1:0] lvs_ff;
   logic [SVSLOPE_W-1:0] svs_ff;
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else       vo_ff <= vg && vq;
      lmf_ff <= fo;
      smf_ff <= F1_W'(ONE - fo);
      lms_ff <= po;
      sms_ff <= P_W'(-po);
      lvf_ff <= gq;
      svf_ff <= F1_W'(ONE - gq);
      lvs_ff <= qsat;
      svs_ff <= -SVSLOPE_W'(qsat);
   end

   assign rsp_valid               = vo_ff;
   assign rsp_liquid_mass_frac    = lmf_ff;
   assign rsp_solid_mass_frac     = smf_ff;
   assign rsp_liquid_mass_slope   = lms_ff;
   assign rsp_solid_mass_slope    = sms_ff;
   assign rsp_liquid_volume_frac  = lvf_ff;
   assign rsp_solid_volume_frac   = svf_ff;
   assign rsp_liquid_volume_slope = lvs_ff;
   assign rsp_solid_volume_slope  = svs_ff;

   // paired dividers stay in lock step; quotients fit the fraction width
   `MZ_ASSERT_NOW(a_mass_lockstep, vf, vp)
   `MZ_ASSERT_NOW(a_div_lockstep, vg, vq)
   `MZ_ASSERT_NOW(a_mass_frac_range, vf && tag_f[1], fq_w[P_W-1:F1_W] == '0)
   `MZ_ASSERT_NOW(a_vol_frac_range, vg, gq_w[QQ_W-1:F1_W] == '0)
   `MZ_ASSERT_NEXT(a_out_follows, vg, rsp_valid)
endmodule
`default_nettype wire

/* hw/rtl/mzpf_divider.sv */
// Pipelined restoring divider: one quotient bit per stage
`default_nettype none
module mzpf_divider
   import mzpf_pkg::*;
#(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32,
   parameter int Q_W   = 48,
   parameter int TAG_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [DEN_W-1:0]  den,
   input  wire logic [TAG_W-1:0]  tag_in,
   output logic                   out_valid,
   output logic [Q_W-1:0]         quot,
   output logic [TAG_W-1:0]       tag_out
);
   // quotient bits Q_W-1 .. 0; num < den * 2^Q_W assumed by the caller
   localparam int R_W = DEN_W + 1;
   logic [Q_W:0]            vld_ff;
   logic [R_W-1:0]          rem_ff  [Q_W+1];
   logic [NUM_W-1:0]        num_ff  [Q_W+1];
   logic [DEN_W-1:0]        den_ff  [Q_W+1];
   logic [Q_W-1:0]          q_ff    [Q_W+1];
   logic [TAG_W-1:0]        tag_ff  [Q_W+1];

   // numerator bits above the quotient seed the partial remainder
   always_comb begin
      vld_ff[0] = in_valid;
      rem_ff[0] = R_W'(num >> Q_W);
      num_ff[0] = num;
      den_ff[0] = den;
      q_ff[0]   = '0;
      tag_ff[0] = tag_in;
   end

   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      localparam int B = Q_W - 1 - i;
      logic [R_W:0]   trial;
      logic [R_W-1:0] rem_in;
      logic           take;
      always_comb begin
         trial  = {rem_ff[i], (B < NUM_W) ? num_ff[i][(B < NUM_W) ? B : 0] : 1'b0};
         take   = trial >= {2'b0, den_ff[i]};
         rem_in = take ? R_W'(trial - {2'b0, den_ff[i]}) : R_W'(trial);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         rem_ff[i+1] <= rem_in;
         num_ff[i+1] <= num_ff[i];
         den_ff[i+1] <= den_ff[i];
         q_ff[i+1]   <= q_ff[i] | (Q_W'(take) << B);
         tag_ff[i+1] <= tag_ff[i];
      end
   end

   assign out_valid = vld_ff[Q_W];
   assign quot      = q_ff[Q_W];
   assign tag_out   = tag_ff[Q_W];
endmodule
`default_nettype wire
